// ===== rtl/dxt_texture_vertical_flip_core_assert.svh =====
// ----------------------------------------------------------------------------
// DXT vertical flip core - assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DXT_TEXTURE_VERTICAL_FLIP_CORE_ASSERT_SVH
`define DXT_TEXTURE_VERTICAL_FLIP_CORE_ASSERT_SVH

// same-cycle implication
`define DXTVF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define DXTVF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/dxtvf_pkg.sv =====
// ----------------------------------------------------------------------------
// DXT vertical flip - package
// Sizes, codes and shared types of the block store and flip path.
// ----------------------------------------------------------------------------
package dxtvf_pkg;

    localparam int MAX_DIM_BLOCKS = 64;
    localparam int STORE_DEPTH    = MAX_DIM_BLOCKS * MAX_DIM_BLOCKS;
    localparam int ADDR_W         = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam int HALF_W       = 64;
    localparam int POS_W        = 6;
    localparam int CFG_FORMAT_W = 2;
    localparam int CFG_DIM_W    = 7;
    localparam int CFG_DATA_W   = 7;
    localparam int CFG_INDEX_W  = 2;
    localparam int DIM_W        = ($clog2(MAX_DIM_BLOCKS + 1) > CFG_DIM_W) ?
                                  $clog2(MAX_DIM_BLOCKS + 1) : CFG_DIM_W;

    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    typedef enum logic [CFG_FORMAT_W-1:0] {
        FMT_DXT1 = 2'd0,
        FMT_DXT3 = 2'd1,
        FMT_DXT5 = 2'd2
    } fmt_e;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLOCK_FORMAT  = 2'd0,
        CFG_WIDTH_BLOCKS  = 2'd1,
        CFG_HEIGHT_BLOCKS = 2'd2
    } cfg_idx_e;

    typedef logic [ADDR_W-1:0]       addr_t;
    typedef logic [HALF_W-1:0]       half_t;
    typedef logic [DIM_W-1:0]        dim_t;
    typedef logic [CFG_FORMAT_W-1:0] fmt_t;

    typedef struct packed {
        logic we;
        addr_t waddr;
        logic re;
        addr_t raddr;
    } ram_cmd_t;

    typedef struct packed {
        logic valid;
        logic in_range;
        fmt_t fmt;
    } rd_ctl_t;

endpackage

// ===== rtl/dxtvf_if.sv =====
// ----------------------------------------------------------------------------
// DXT vertical flip - channel interfaces
// Request channel (store or fetch items) and response channel (flipped blocks).
// ----------------------------------------------------------------------------
interface dxtvf_req_if;
    import dxtvf_pkg::*;

    logic              valid;
    logic              ready;
    logic              func;
    logic [POS_W-1:0]  block_row;
    logic [POS_W-1:0]  block_col;
    logic [HALF_W-1:0] alpha_half;
    logic [HALF_W-1:0] color_half;

    modport source (
        output valid, func, block_row, block_col, alpha_half, color_half,
        input  ready
    );

    modport sink (
        input  valid, func, block_row, block_col, alpha_half, color_half,
        output ready
    );
endinterface

interface dxtvf_rsp_if;
    import dxtvf_pkg::*;

    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] flipped_alpha;
    logic [HALF_W-1:0] flipped_color;
    logic              out_of_range;

    modport source (
        output valid, flipped_alpha, flipped_color, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, flipped_alpha, flipped_color, out_of_range,
        output ready
    );
endinterface

// ===== rtl/dxt_texture_vertical_flip_core.sv =====
// ----------------------------------------------------------------------------
// DXT vertical flip core - top level
// Block store of one compressed level with vertically flipped fetch.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   req     | in  | func, block_row, block_col, alpha_half, color_half
//   rsp     | out | flipped_alpha, flipped_color, out_of_range
//   cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One item per cycle is accepted while req.ready is high; a store is
// written at its accept edge. A fetch reads both block RAMs at its accept
// edge, and the read data is flipped into the response register on rsp.
// A stalled response holds the read stage; req.ready drops only when both
// the read stage and the response register are full.
// Reset clears the configuration to DXT1, one by one block; RAMs keep data.
// ----------------------------------------------------------------------------
`include "dxt_texture_vertical_flip_core_assert.svh"

module dxt_texture_vertical_flip_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dxtvf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dxtvf_pkg::CFG_DATA_W-1:0]  cfg_data,
    dxtvf_req_if.sink                         req,
    dxtvf_rsp_if.source                       rsp
);
    import dxtvf_pkg::*;

    ram_cmd_t ram_cmd;
    rd_ctl_t  rd_ctl;
    logic     rd_advance;
    half_t    alpha_rdata;
    half_t    color_rdata;
    logic     req_take;
    logic     rsp_nonzero;

    dxtvf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req        (req),
        .rd_advance (rd_advance),
        .ram_cmd    (ram_cmd),
        .rd_ctl     (rd_ctl)
    );

    dxtvf_ram #(
        .WIDTH (HALF_W),
        .DEPTH (STORE_DEPTH)
    ) u_alpha_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (req.alpha_half),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (alpha_rdata)
    );

    dxtvf_ram #(
        .WIDTH (HALF_W),
        .DEPTH (STORE_DEPTH)
    ) u_color_ram (
        .clk   (clk),
        .we    (ram_cmd.we),
        .waddr (ram_cmd.waddr),
        .wdata (req.color_half),
        .re    (ram_cmd.re),
        .raddr (ram_cmd.raddr),
        .rdata (color_rdata)
    );

    dxtvf_flip u_flip (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_ctl      (rd_ctl),
        .alpha_rdata (alpha_rdata),
        .color_rdata (color_rdata),
        .rd_advance  (rd_advance),
        .rsp         (rsp)
    );

    assign req_take    = req.valid && req.ready;
    assign rsp_nonzero = |{rsp.flipped_alpha, rsp.flipped_color};

    `DXTVF_ASSERT_NEXT(a_fetch_tracked, req_take && (req.func == FUNC_FETCH), rd_ctl.valid)
    `DXTVF_ASSERT_NEXT(a_store_silent, req_take && (req.func == FUNC_STORE), !rd_ctl.valid)
    `DXTVF_ASSERT_IMP(a_no_overrun, rd_ctl.valid && rsp.valid && !rsp.ready, !req.ready)
    `DXTVF_ASSERT_IMP(a_oor_zero, rsp.valid && rsp.out_of_range, !rsp_nonzero)

endmodule

// ===== rtl/dxtvf_ram.sv =====
// ----------------------------------------------------------------------------
// DXT vertical flip - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dxtvf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/dxtvf_ctrl.sv =====
// ----------------------------------------------------------------------------
// DXT vertical flip - request control
// Configuration registers, range check, store write and mirror-row read.
// ----------------------------------------------------------------------------
module dxtvf_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [dxtvf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dxtvf_pkg::CFG_DATA_W-1:0]  cfg_data,
    dxtvf_req_if.sink                        req,
    input  logic                             rd_advance,
    output dxtvf_pkg::ram_cmd_t              ram_cmd,
    output dxtvf_pkg::rd_ctl_t               rd_ctl
);
    import dxtvf_pkg::*;

    fmt_t                 format_reg, format_next;
    logic [CFG_DIM_W-1:0] width_reg, width_next;
    logic [CFG_DIM_W-1:0] height_reg, height_next;
    rd_ctl_t              rd_ctl_reg, rd_ctl_next;

    dim_t wd, ht, row_ext, col_ext, src_row;
    logic in_range, accept;

    always_comb
    begin
        format_next = format_reg;
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BLOCK_FORMAT:  format_next = cfg_data[CFG_FORMAT_W-1:0];
                CFG_WIDTH_BLOCKS:  width_next  = cfg_data[CFG_DIM_W-1:0];
                CFG_HEIGHT_BLOCKS: height_next = cfg_data[CFG_DIM_W-1:0];
                default:           format_next = format_reg;
            endcase
        end
    end

    always_comb
    begin
        wd = (DIM_W'(width_reg) > DIM_W'(MAX_DIM_BLOCKS)) ?
             DIM_W'(MAX_DIM_BLOCKS) : DIM_W'(width_reg);
        ht = (DIM_W'(height_reg) > DIM_W'(MAX_DIM_BLOCKS)) ?
             DIM_W'(MAX_DIM_BLOCKS) : DIM_W'(height_reg);
        row_ext  = DIM_W'(req.block_row);
        col_ext  = DIM_W'(req.block_col);
        in_range = (row_ext < ht) && (col_ext < wd);
        src_row  = ht - DIM_W'(1) - row_ext;
    end

    assign req.ready = !rd_ctl_reg.valid || rd_advance;
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        ram_cmd.we    = accept && (req.func == FUNC_STORE) && in_range;
        ram_cmd.waddr = ADDR_W'(row_ext) * ADDR_W'(MAX_DIM_BLOCKS) + ADDR_W'(col_ext);
        ram_cmd.re    = accept && (req.func == FUNC_FETCH) && in_range;
        ram_cmd.raddr = ADDR_W'(src_row) * ADDR_W'(MAX_DIM_BLOCKS) + ADDR_W'(col_ext);
    end

    always_comb
    begin
        rd_ctl_next = rd_ctl_reg;
        if (accept)
        begin
            rd_ctl_next.valid    = (req.func == FUNC_FETCH);
            rd_ctl_next.in_range = in_range;
            rd_ctl_next.fmt      = format_reg;
        end
        else if (rd_advance)
        begin
            rd_ctl_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= FMT_DXT1;
            width_reg  <= CFG_DIM_W'(1);
            height_reg <= CFG_DIM_W'(1);
            rd_ctl_reg <= '0;
        end
        else
        begin
            format_reg <= format_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            rd_ctl_reg <= rd_ctl_next;
        end
    end

    assign rd_ctl = rd_ctl_reg;

endmodule

// ===== rtl/dxtvf_flip.sv =====
// ----------------------------------------------------------------------------
// DXT vertical flip - flip and response stage
// Reverses pixel rows of the fetched block and holds the response register.
// ----------------------------------------------------------------------------
module dxtvf_flip (
    input  logic               clk,
    input  logic               rst_n,
    input  dxtvf_pkg::rd_ctl_t rd_ctl,
    input  dxtvf_pkg::half_t   alpha_rdata,
    input  dxtvf_pkg::half_t   color_rdata,
    output logic               rd_advance,
    dxtvf_rsp_if.source        rsp
);
    import dxtvf_pkg::*;

    logic  rsp_valid_reg, rsp_valid_next;
    half_t alpha_reg, alpha_next;
    half_t color_reg, color_next;
    logic  oor_reg, oor_next;
    half_t alpha_flip;

    function automatic half_t flip_color(input half_t c);
        return {c[39:32], c[47:40], c[55:48], c[63:56], c[31:0]};
    endfunction

    function automatic half_t flip_explicit(input half_t a);
        return {a[15:0], a[31:16], a[47:32], a[63:48]};
    endfunction

    function automatic half_t flip_interp(input half_t a);
        return {a[27:16], a[39:28], a[51:40], a[63:52], a[15:0]};
    endfunction

    always_comb
    begin
        unique case (rd_ctl.fmt)
            FMT_DXT3: alpha_flip = flip_explicit(alpha_rdata);
            FMT_DXT5: alpha_flip = flip_interp(alpha_rdata);
            default:  alpha_flip = '0;
        endcase
    end

    assign rd_advance = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        alpha_next     = alpha_reg;
        color_next     = color_reg;
        oor_next       = oor_reg;
        if (rd_advance)
        begin
            rsp_valid_next = rd_ctl.valid;
            if (rd_ctl.valid)
            begin
                alpha_next = rd_ctl.in_range ? alpha_flip : '0;
                color_next = rd_ctl.in_range ? flip_color(color_rdata) : '0;
                oor_next   = !rd_ctl.in_range;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alpha_reg <= alpha_next;
        color_reg <= color_next;
        oor_reg   <= oor_next;
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.flipped_alpha = alpha_reg;
    assign rsp.flipped_color = color_reg;
    assign rsp.out_of_range  = oor_reg;

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// DXT vertical flip core - testbench
// Stores 4x4 blocks and fetches them back through their mirror row. Each
// flipped block is checked against a local copy of the store and of the row
// reversal for DXT1, DXT3 and DXT5, with random idling on both channels,
// several layouts (odd, zero and oversized dimensions) and one long stall.
// ----------------------------------------------------------------------------
module tb;
    import dxtvf_pkg::*;

    localparam fmt_t FMT_SPARE = 2'd3;

    typedef struct {
        half_t alpha;
        half_t colour;
        logic  outside;
    } flipped_block_t;

    class flip_scoreboard;
        half_t          alpha_mem [STORE_DEPTH];
        half_t          colour_mem [STORE_DEPTH];
        bit             written [STORE_DEPTH];
        fmt_t           fmt;
        int             width_eff;
        int             height_eff;
        flipped_block_t due [$];
        int             errors;

        function new();
            fmt        = FMT_DXT1;
            width_eff  = 1;
            height_eff = 1;
            errors     = 0;
        endfunction

        function void set_layout(fmt_t f, int w, int h);
            fmt        = f;
            width_eff  = (w > MAX_DIM_BLOCKS) ? MAX_DIM_BLOCKS : w;
            height_eff = (h > MAX_DIM_BLOCKS) ? MAX_DIM_BLOCKS : h;
        endfunction

        function bit is_inside(int row, int col);
            return row >= 0 && col >= 0 && row < height_eff && col < width_eff;
        endfunction

        function bit fetch_allowed(int row, int col);
            if (!is_inside(row, col))
                return 1'b1;
            return written[(height_eff - 1 - row) * MAX_DIM_BLOCKS + col];
        endfunction

        function half_t flip_colour_rows(half_t c);
            return {c[39:32], c[47:40], c[55:48], c[63:56], c[31:0]};
        endfunction

        function half_t flip_explicit_alpha(half_t a);
            return {a[15:0], a[31:16], a[47:32], a[63:48]};
        endfunction

        function half_t flip_alpha_indices(half_t a);
            return {a[27:16], a[39:28], a[51:40], a[63:52], a[15:0]};
        endfunction

        function flipped_block_t predict_fetch(int row, int col);
            flipped_block_t blk;
            int             src;
            blk.alpha   = '0;
            blk.colour  = '0;
            blk.outside = 1'b1;
            if (is_inside(row, col))
            begin
                src         = (height_eff - 1 - row) * MAX_DIM_BLOCKS + col;
                blk.outside = 1'b0;
                blk.colour  = flip_colour_rows(colour_mem[src]);
                case (fmt)
                    FMT_DXT3: blk.alpha = flip_explicit_alpha(alpha_mem[src]);
                    FMT_DXT5: blk.alpha = flip_alpha_indices(alpha_mem[src]);
                    default:  blk.alpha = '0;
                endcase
            end
            return blk;
        endfunction

        function void note_item(logic func, int row, int col, half_t a, half_t c);
            int addr;
            if (func == FUNC_STORE)
            begin
                if (is_inside(row, col))
                begin
                    addr             = row * MAX_DIM_BLOCKS + col;
                    alpha_mem[addr]  = a;
                    colour_mem[addr] = c;
                    written[addr]    = 1'b1;
                end
            end
            else
                due.push_back(predict_fetch(row, col));
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_block(half_t a, half_t c, logic oor);
            flipped_block_t want;
            if (due.size() == 0)
            begin
                report_mismatch($sformatf("unexpected block alpha %h colour %h", a, c));
                return;
            end
            want = due.pop_front();
            if (a !== want.alpha)
                report_mismatch($sformatf("flipped_alpha %h, want %h", a, want.alpha));
            if (c !== want.colour)
                report_mismatch($sformatf("flipped_color %h, want %h", c, want.colour));
            if (oor !== want.outside)
                report_mismatch($sformatf("out_of_range %b, want %b", oor, want.outside));
        endtask

        task close();
            while (due.size() != 0)
            begin
                void'(due.pop_front());
                report_mismatch("fetched block never returned");
            end
        endtask
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dxtvf_req_if req_ch ();
    dxtvf_rsp_if rsp_ch ();

    flip_scoreboard sb = new();

    int src_idle_pct;
    int sink_idle_pct;
    bit hold_request;
    bit hold_taken;
    int hold_left;
    int last_row;
    int last_col;

    dxt_texture_vertical_flip_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic push_item(input logic func, input int row, input int col,
                             input half_t a, input half_t c);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.func       <= func;
        req_ch.block_row  <= row[POS_W-1:0];
        req_ch.block_col  <= col[POS_W-1:0];
        req_ch.alpha_half <= a;
        req_ch.color_half <= c;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_item(func, row, col, a, c);
        if (func == FUNC_STORE && sb.is_inside(row, col))
        begin
            last_row = row;
            last_col = col;
        end
    endtask

    task automatic settle();
        int guard;
        guard = 0;
        req_ch.valid <= 1'b0;
        while (sb.due.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic program_layout(input fmt_t fmt, input int w, input int h);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_BLOCK_FORMAT;
        cfg_data  <= CFG_DATA_W'(fmt);
        @(posedge clk);
        cfg_index <= CFG_WIDTH_BLOCKS;
        cfg_data  <= CFG_DATA_W'(w);
        @(posedge clk);
        cfg_index <= CFG_HEIGHT_BLOCKS;
        cfg_data  <= CFG_DATA_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_layout(fmt, w, h);
        last_row = -1;
    endtask

    task automatic random_phase(input fmt_t fmt, input int w, input int h,
                                input int budget);
        int   done;
        int   pick;
        int   row;
        int   col;
        int   tries;
        logic func;
        program_layout(fmt, w, h);
        done = 0;
        while (done < budget)
        begin
            pick = $urandom_range(0, 99);
            func = FUNC_FETCH;
            if (pick < 12 || sb.width_eff == 0 || sb.height_eff == 0)
            begin
                func = 1'($urandom_range(0, 1));
                row  = $urandom_range(0, 63);
                col  = $urandom_range(0, 63);
            end
            else if (pick < 50 || last_row < 0)
            begin
                func = FUNC_STORE;
                row  = $urandom_range(0, sb.height_eff - 1);
                col  = $urandom_range(0, sb.width_eff - 1);
            end
            else if (pick < 75)
            begin
                row = sb.height_eff - 1 - last_row;
                col = last_col;
            end
            else
            begin
                tries = 0;
                do
                begin
                    row = $urandom_range(0, sb.height_eff - 1);
                    col = $urandom_range(0, sb.width_eff - 1);
                    tries++;
                end
                while (!sb.fetch_allowed(row, col) && tries < 8);
            end
            if (func == FUNC_FETCH && !sb.fetch_allowed(row, col))
                func = FUNC_STORE;
            if (func == FUNC_FETCH || sb.is_inside(row, col))
                done++;
            push_item(func, row, col, {$urandom, $urandom}, {$urandom, $urandom});
        end
    endtask

    initial
    begin
        hold_left  = 0;
        hold_taken = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                sb.check_block(rsp_ch.flipped_alpha, rsp_ch.flipped_color,
                               rsp_ch.out_of_range);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_BLOCK_FORMAT;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.func       <= FUNC_STORE;
        req_ch.block_row  <= '0;
        req_ch.block_col  <= '0;
        req_ch.alpha_half <= '0;
        req_ch.color_half <= '0;
        src_idle_pct  = 14;
        sink_idle_pct = 60;
        hold_request  = 1'b0;
        last_row      = -1;
        last_col      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset layout: DXT1, one by one block
        push_item(FUNC_STORE, 0, 0, '1, '1);
        push_item(FUNC_FETCH, 0, 0, '0, '0);
        push_item(FUNC_FETCH, 0, 1, '0, '0);
        push_item(FUNC_STORE, 1, 0, '1, '1);

        program_layout(FMT_DXT3, 64, 64);
        push_item(FUNC_STORE, 63, 63, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        push_item(FUNC_STORE, 0, 63, '1, '0);
        push_item(FUNC_FETCH, 0, 63, '0, '0);
        push_item(FUNC_FETCH, 63, 63, '0, '0);
        push_item(FUNC_STORE, 0, 0, 64'haaaa_5555_aaaa_5555, 64'h5555_aaaa_5555_aaaa);
        push_item(FUNC_FETCH, 63, 0, '0, '0);

        // odd height, oversized width, DXT5
        program_layout(FMT_DXT5, 127, 3);
        push_item(FUNC_STORE, 1, 5, 64'h0123_4567_89ab_cdef, 64'h0f1e_2d3c_4b5a_6978);
        push_item(FUNC_FETCH, 1, 5, '0, '0);
        push_item(FUNC_STORE, 0, 63, {$urandom, $urandom}, {$urandom, $urandom});
        push_item(FUNC_FETCH, 2, 63, '0, '0);
        push_item(FUNC_STORE, 3, 0, '1, '1);
        push_item(FUNC_FETCH, 3, 0, '0, '0);

        program_layout(FMT_SPARE, 0, 5);
        push_item(FUNC_FETCH, 0, 0, '0, '0);
        push_item(FUNC_STORE, 0, 0, '0, '0);

        program_layout(FMT_SPARE, 4, 4);
        push_item(FUNC_STORE, 0, 0, {$urandom, $urandom}, {$urandom, $urandom});
        push_item(FUNC_FETCH, 3, 0, '0, '0);

        program_layout(FMT_DXT1, 2, 0);
        push_item(FUNC_FETCH, 1, 1, '0, '0);

        random_phase(FMT_DXT1, 4, 3, 60);
        random_phase(FMT_DXT3, 7, 5, 60);
        random_phase(FMT_DXT5, 1, 1, 40);
        src_idle_pct  = 60;
        sink_idle_pct = 14;
        random_phase(FMT_DXT5, 64, 64, 70);
        random_phase(FMT_SPARE, 13, 9, 60);
        random_phase(FMT_DXT3, 127, 127, 60);
        random_phase(FMT_DXT3, 0, 3, 10);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_phase(FMT_DXT1, 2, 6, 60);
        random_phase(FMT_DXT5, 100, 1, 50);

        program_layout(FMT_DXT3, 8, 8);
        for (int r = 0; r < 8; r++)
            push_item(FUNC_STORE, r, 0, {$urandom, $urandom}, {$urandom, $urandom});
        hold_request = 1'b1;
        for (int k = 0; k < 24; k++)
            push_item(FUNC_FETCH, k % 8, 0, '0, '0);

        settle();
        sb.close();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
